>>> src/mkd_pkg.sv
// Package for the mesh key duplicate filter: request and result types,
// store geometry and helper functions. No dependencies.
`timescale 1ns / 1ps
package mkd_pkg;

  localparam int unsigned MaxMeshes = 32768;
  localparam int unsigned AddrW     = $clog2(MaxMeshes);
  localparam int unsigned CountW    = $clog2(MaxMeshes + 1);
  localparam int unsigned KeyW      = 32 * 7 + 48;
  localparam logic [15:0] KeptMax   = 16'hFFFF;
  localparam logic [39:0] TotalMax  = 40'hFF_FFFF_FFFF;
  // (2^25 + 1) / 3: a 24-bit count times this, shifted right by 25, is the count / 3.
  localparam logic [24:0] Recip3    = 25'h0AA_AAAB;

  typedef struct packed {
    logic        scene_start;
    logic [31:0] texture_key;
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
    logic [23:0] index_count;
    logic [23:0] vertex_count;
  } req_t;

  typedef struct packed {
    logic        keep;
    logic [15:0] kept_before;
    logic [39:0] dropped_triangles;
    logic        overflow;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  function automatic logic box_equal(logic [31:0] a, logic [31:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (a_nan || b_nan) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b1;
    return a == b;
  endfunction

  function automatic logic [KeyW-1:0] pack_key(req_t r);
    return {r.texture_key, r.min_x, r.min_y, r.min_z, r.max_x, r.max_y, r.max_z,
            r.index_count, r.vertex_count};
  endfunction

  function automatic logic key_equal(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
    logic eq;
    eq = (a[KeyW-1 -: 32] == b[KeyW-1 -: 32]) && (a[47:0] == b[47:0]);
    for (int k = 0; k < 6; k++) begin
      eq = eq && box_equal(a[48 + 32 * k +: 32], b[48 + 32 * k +: 32]);
    end
    return eq;
  endfunction

endpackage

>>> src/mkd_store.sv
// Key store: one synchronous memory, one write and one registered read port.
// Depends on mkd_pkg.
`timescale 1ns / 1ps
module mkd_store (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [mkd_pkg::AddrW-1:0] waddr_i,
  input  logic [mkd_pkg::KeyW-1:0]  wdata_i,
  input  logic [mkd_pkg::AddrW-1:0] raddr_i,
  output logic [mkd_pkg::KeyW-1:0]  rdata_o
);
  import mkd_pkg::*;

  logic [KeyW-1:0] mem [MaxMeshes];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/mesh_key_dedup.sv
// Top level of the mesh key duplicate filter: scan sequencer and counters.
// Depends on mkd_pkg and mkd_store.
`timescale 1ns / 1ps
// Each request is compared against every key recorded so far in the scene,
// one stored key per cycle through the single read port of the key store.
// Busy is high through the scan and the done state after a request is taken (the
// scan ends at once for an empty store or a scene-start request, and a match ends
// it early). The result appears on res_o for one cycle with res_valid_o, in the
// first cycle that busy is low, and the receiver cannot stall it. A scene-start
// request clears the counters; the store needs no clearing since only
// recorded entries are ever read.
module mesh_key_dedup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mkd_pkg::req_t req_i,
  output logic          res_valid_o,
  output mkd_pkg::res_t res_o
);
  import mkd_pkg::*;

  state_e state_q, state_d;
  logic [CountW-1:0] unique_q, unique_d;
  logic [15:0]       surv_q, surv_d;
  logic [39:0]       total_q, total_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [CountW-1:0] limit_q, limit_d;
  logic              found_q, found_d;
  logic              rvalid_q, rvalid_d;
  logic [KeyW-1:0]   key_q;
  logic [23:0]       tri_q;
  logic [48:0]       prod;
  logic              we;
  logic [KeyW-1:0]   rdata;
  logic [AddrW-1:0]  raddr;
  res_t              res_q, res_d;
  logic              strobe_q, strobe_d;
  logic              accept;
  logic [40:0]       sum;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign raddr  = idx_q[AddrW-1:0];
  assign prod   = 49'(req_i.index_count) * 49'(Recip3);

  mkd_store u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(unique_q[AddrW-1:0]),
    .wdata_i(key_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= pack_key(req_i);
      tri_q <= prod[48:25];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: begin
        if ((rvalid_q && key_equal(rdata, key_q)) || (idx_q >= limit_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // The read issued at idx_q returns in the next cycle; rvalid_q tags it.
  always_comb begin
    idx_d    = idx_q;
    limit_d  = limit_q;
    found_d  = found_q;
    rvalid_d = 1'b0;
    unique_d = unique_q;
    surv_d   = surv_q;
    total_d  = total_q;
    res_d    = res_q;
    strobe_d = 1'b0;
    we       = 1'b0;
    sum      = {1'b0, total_q} + {17'd0, tri_q};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          found_d = 1'b0;
          if (req_i.scene_start) begin
            unique_d = '0;
            surv_d   = '0;
            total_d  = '0;
            limit_d  = '0;
          end else begin
            limit_d = unique_q;
          end
        end
      end
      ST_SCAN: begin
        if (rvalid_q && key_equal(rdata, key_q)) begin
          found_d = 1'b1;
        end else if (idx_q < limit_q) begin
          idx_d    = idx_q + 1'b1;
          rvalid_d = 1'b1;
        end
      end
      ST_DONE: begin
        strobe_d          = 1'b1;
        res_d.kept_before = surv_q;
        res_d.keep        = !found_q;
        res_d.overflow    = 1'b0;
        if (found_q) begin
          total_d = sum[40] ? TotalMax : sum[39:0];
        end else begin
          if (unique_q < CountW'(MaxMeshes)) begin
            we       = 1'b1;
            unique_d = unique_q + 1'b1;
          end else begin
            res_d.overflow = 1'b1;
          end
          if (surv_q != KeptMax) surv_d = surv_q + 1'b1;
        end
        res_d.dropped_triangles = total_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      unique_q <= '0;
      surv_q   <= '0;
      total_q  <= '0;
      idx_q    <= '0;
      limit_q  <= '0;
      found_q  <= 1'b0;
      rvalid_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      unique_q <= unique_d;
      surv_q   <= surv_d;
      total_q  <= total_d;
      idx_q    <= idx_d;
      limit_q  <= limit_d;
      found_q  <= found_d;
      rvalid_q <= rvalid_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = strobe_q;
  assign res_o       = res_q;

endmodule

>>> src/mkd_checker.sv
// Port-level checker for the mesh key duplicate filter, bound to the top.
// Depends on mkd_pkg.
`timescale 1ns / 1ps
module mkd_assert (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_i,
  input logic          res_valid_i,
  input mkd_pkg::res_t res_i
);
  import mkd_pkg::*;

  // A result strobe lasts one cycle and leaves the block idle.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |=> !res_valid_i) else $error("result strobe held");
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !busy_i) else $error("result while busy");
  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> busy_i) else $error("request not taken");
  // Dropped items never flag overflow.
  a_ovf_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_i.overflow) |-> res_i.keep) else $error("overflow on drop");

endmodule

bind mesh_key_dedup mkd_assert u_mkd_assert (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start),
  .busy_i     (busy),
  .res_valid_i(res_valid_o),
  .res_i      (res_o)
);

>>> tb/mkd_checker.sv
// Checker for the mesh key duplicate filter: predicts each result from the
// accepted requests and compares it with the result port. Depends on mkd_pkg.
`timescale 1ns / 1ps
module mkd_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  mkd_pkg::req_t req_i,
  input  logic          res_valid_i,
  input  mkd_pkg::res_t res_i,
  output int            errors_o,
  output int            pending_o
);
  import mkd_pkg::*;

  req_t        scene_keys[$];
  logic [15:0] survivors;
  logic [39:0] tri_total;
  res_t        expected_q[$];

  function automatic bit is_nan(logic [31:0] v);
    return v[30:23] == 8'hFF && v[22:0] != 23'd0;
  endfunction

  // Zeros of either sign match; a NaN matches nothing.
  function automatic bit same_bound(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b1;
    return a == b;
  endfunction

  function automatic bit same_mesh(req_t a, req_t b);
    return a.texture_key == b.texture_key && a.index_count == b.index_count &&
           a.vertex_count == b.vertex_count && same_bound(a.min_x, b.min_x) &&
           same_bound(a.min_y, b.min_y) && same_bound(a.min_z, b.min_z) &&
           same_bound(a.max_x, b.max_x) && same_bound(a.max_y, b.max_y) &&
           same_bound(a.max_z, b.max_z);
  endfunction

  task automatic predict_dedup(req_t r);
    res_t      e;
    bit        seen;
    logic [40:0] sum;
    if (r.scene_start) begin
      scene_keys.delete();
      survivors = '0;
      tri_total = '0;
    end
    seen = 1'b0;
    foreach (scene_keys[i]) if (!seen && same_mesh(scene_keys[i], r)) seen = 1'b1;
    e = '0;
    e.kept_before = survivors;
    if (seen) begin
      sum = {1'b0, tri_total} + 41'(r.index_count / 3);
      tri_total = sum[40] ? TotalMax : sum[39:0];
    end else begin
      e.keep = 1'b1;
      if (scene_keys.size() < MaxMeshes) scene_keys.push_back(r);
      else e.overflow = 1'b1;
      if (survivors != KeptMax) survivors++;
    end
    e.dropped_triangles = tri_total;
    expected_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      scene_keys.delete();
      expected_q.delete();
      survivors = '0;
      tri_total = '0;
      errors_o  = 0;
    end else begin
      // A result leaves in a later cycle than its request, so check first.
      if (res_valid_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request pending: %p", $time, res_i);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          if (res_i.keep !== e.keep || res_i.kept_before !== e.kept_before ||
              res_i.dropped_triangles !== e.dropped_triangles ||
              res_i.overflow !== e.overflow) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, res_i);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i) predict_dedup(req_i);
    end
  end

  assign pending_o = expected_q.size();
endmodule

>>> tb/mesh_key_dedup_test.sv
// Testbench top for mesh_key_dedup: drives directed and random requests and
// reports the verdict. Depends on mkd_pkg, mesh_key_dedup and mkd_checker.
`timescale 1ns / 1ps
module mesh_key_dedup_test;
  import mkd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic res_valid;
  res_t res;
  int   errors;
  int   pending;
  logic busy_seen = 1'b0;
  int   idle_pct;
  req_t palette[$];

  always #5 clk_i = ~clk_i;

  mesh_key_dedup i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req), .res_valid_o(res_valid), .res_o(res)
  );

  mkd_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .req_i(req),
    .res_valid_i(res_valid), .res_i(res), .errors_o(errors), .pending_o(pending)
  );

  // Busy is stable at the falling edge, ahead of the edge that may accept.
  always @(negedge clk_i) busy_seen = busy;

  task automatic send_request(req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy_seen);
  endtask

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'h7FC0_0000 | $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t fresh_mesh();
    req_t r;
    r.scene_start  = 1'b0;
    r.texture_key  = $urandom;
    r.min_x = pick_bound(); r.min_y = pick_bound(); r.min_z = pick_bound();
    r.max_x = pick_bound(); r.max_y = pick_bound(); r.max_z = pick_bound();
    r.index_count  = 24'($urandom);
    r.vertex_count = 24'($urandom);
    return r;
  endfunction

  // Repeats a known mesh, sometimes with the sign of a zero bound or a vertex count bit flipped.
  function automatic req_t repeat_mesh(req_t r);
    if ($urandom_range(3) == 0 && r.min_x[30:0] == 31'd0) r.min_x[31] = ~r.min_x[31];
    if ($urandom_range(3) == 0 && r.max_z[30:0] == 31'd0) r.max_z[31] = ~r.max_z[31];
    if ($urandom_range(9) == 0) r.vertex_count[$urandom_range(23)] ^= 1'b1;
    r.scene_start = 1'b0;
    return r;
  endfunction

  initial begin
    #200_000_000;
    $display("mesh_key_dedup_test: errors");
    $finish;
  end

  initial begin
    req_t r;
    req_t big;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, signed zeros, NaN bounds and scene clearing.
    idle_pct = 0;
    r = '0;
    send_request(r);
    send_request(r);
    r.min_x = 32'h8000_0000; r.max_y = 32'h8000_0000; r.index_count = 24'd5;
    send_request(r);
    r = '1; r.scene_start = 1'b0;
    send_request(r);
    send_request(r);
    r.min_x = 32'h7F80_0000; r.min_y = 32'h7F80_0000; r.min_z = 32'h7F80_0000;
    r.max_x = 32'hFF80_0000; r.max_y = 32'hFF80_0000; r.max_z = 32'hFF80_0000;
    send_request(r);
    send_request(r);
    for (int n = 0; n < 4; n++) begin
      r = '0; r.texture_key = 32'hFFFF_FFFF; r.index_count = 24'(n);
      send_request(r);
      send_request(r);
    end
    r = '0; r.index_count = 24'hFF_FFFF; r.vertex_count = 24'hFF_FFFF;
    send_request(r);
    send_request(r);
    r.scene_start = 1'b1;
    send_request(r);
    r.scene_start = 1'b0;
    send_request(r);

    // Random scenes built from a small palette of meshes.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 45 : 0;
      for (int n = 0; n < 340; n++) begin
        if ($urandom_range(24) == 0 || palette.size() == 0) begin
          palette.delete();
          r = fresh_mesh();
          r.scene_start = 1'b1;
          palette.push_back(r);
        end else if ($urandom_range(1) == 0) begin
          r = repeat_mesh(palette[$urandom_range(palette.size() - 1)]);
        end else begin
          r = fresh_mesh();
          if (palette.size() < 12) palette.push_back(r);
        end
        send_request(r);
      end
    end

    // Short run of one duplicated mesh with the largest index count.
    idle_pct = 0;
    big = fresh_mesh();
    big.min_x = 32'h3F80_0000;
    big.index_count = 24'hFF_FFFF;
    big.scene_start = 1'b1;
    send_request(big);
    big.scene_start = 1'b0;
    for (int n = 0; n < 60; n++) send_request(big);
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("mesh_key_dedup_test: clean");
    end else begin
      $display("mesh_key_dedup_test: errors");
    end
    $finish;
  end
endmodule
